// File: rtl/awpr_pkg.sv
// Package for the area weighted pixel resampler: widths, types, stage
// advance struct and the per-axis weight function. No dependencies.
package awpr_pkg;

  localparam int FRAC_BITS = 8;           // fraction bits of an axis weight
  localparam int WW        = FRAC_BITS + 1;
  localparam int W2W       = 2 * WW;
  localparam int PW        = W2W + 8;     // weight times one 8-bit channel
  localparam int SW        = PW + 4;      // sum of nine products
  localparam int SHIFT     = 2 * FRAC_BITS;
  localparam int NPIX      = 9;
  localparam int NCHAN     = 3;
  localparam int PIX_CENTRE = 4;

  // border flag bit positions
  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_RIGHT = 1;
  localparam int FLAG_FIRST = 2;
  localparam int FLAG_LAST  = 3;

  typedef logic [WW-1:0]  wgt_t;
  typedef logic [W2W-1:0] wgt2_t;
  typedef logic [PW-1:0]  prod_t;
  typedef logic [SW-1:0]  sum_t;
  typedef logic [7:0]     chan_t;
  typedef logic [23:0]    rgb_t;

  // lead = max(half - f, 0), trail = max(f - half, 0)
  typedef struct packed {
    wgt_t lead;
    wgt_t middle;
    wgt_t trail;
  } axis_wgt_t;

  // per-stage advance enables, stage 1 is the input register
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

  localparam wgt_t W_ONE  = wgt_t'(1) << FRAC_BITS;
  localparam wgt_t W_HALF = wgt_t'(1) << (FRAC_BITS - 1);

  // Overlap of a unit square centered on the point with the three pixels of
  // one axis. The fraction is rescaled from 8 bits to FRAC_BITS, truncating.
  function automatic axis_wgt_t axis_weights(input logic [7:0] f8);
    logic [FRAC_BITS+7:0] t;
    wgt_t      f;
    axis_wgt_t w;
    t = {f8, {FRAC_BITS{1'b0}}};
    f = wgt_t'(t[FRAC_BITS+7:8]);
    w.lead   = (W_HALF > f) ? wgt_t'(W_HALF - f) : '0;
    w.trail  = (f > W_HALF) ? wgt_t'(f - W_HALF) : '0;
    w.middle = wgt_t'(W_ONE - w.lead - w.trail);
    return w;
  endfunction

endpackage

// File: rtl/awpr_in_if.sv
// Input channel of the resampler: sample position, border flags and the
// 3x3 ARGB neighborhood. No dependencies.
interface awpr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frac_x;
  logic [7:0]  frac_y;
  logic [3:0]  border_flags;
  logic [31:0] pix_upper_left;
  logic [31:0] pix_upper_mid;
  logic [31:0] pix_upper_right;
  logic [31:0] pix_mid_left;
  logic [31:0] pix_centre;
  logic [31:0] pix_mid_right;
  logic [31:0] pix_lower_left;
  logic [31:0] pix_lower_mid;
  logic [31:0] pix_lower_right;

  modport source (
    output valid, frac_x, frac_y, border_flags,
    output pix_upper_left, pix_upper_mid, pix_upper_right,
    output pix_mid_left, pix_centre, pix_mid_right,
    output pix_lower_left, pix_lower_mid, pix_lower_right,
    input  ready
  );
  modport sink (
    input  valid, frac_x, frac_y, border_flags,
    input  pix_upper_left, pix_upper_mid, pix_upper_right,
    input  pix_mid_left, pix_centre, pix_mid_right,
    input  pix_lower_left, pix_lower_mid, pix_lower_right,
    output ready
  );
endinterface

// File: rtl/awpr_out_if.sv
// Output channel of the resampler: one resampled ARGB pixel per beat.
// No dependencies.
interface awpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_alpha;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, out_alpha, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

// File: rtl/awpr_front.sv
// Front end: border substitution, axis weights (stage 1) and the nine
// 2-D weights (stage 2). Depends on awpr_pkg.
module awpr_front (
  input  logic                                clk,
  input  awpr_pkg::adv_t                      adv,
  input  logic [7:0]                          frac_x,
  input  logic [7:0]                          frac_y,
  input  logic [3:0]                          border_flags,
  input  logic [awpr_pkg::NPIX-1:0][31:0]     pix,
  output awpr_pkg::wgt2_t [awpr_pkg::NPIX-1:0] w2,
  output awpr_pkg::rgb_t [awpr_pkg::NPIX-1:0] rgb2,
  output logic [7:0]                          alpha2
);
  import awpr_pkg::*;

  rgb_t [NPIX-1:0] sel_rgb;
  rgb_t [NPIX-1:0] rgb1;
  axis_wgt_t       wx;
  axis_wgt_t       wy;
  logic [7:0]      alpha1;
  wgt_t [2:0]      wcol;
  wgt_t [2:0]      wrow;

  // missing neighbors take the center row / column
  always_comb begin
    logic rs;
    logic cs;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rs = ((r == 0) && border_flags[FLAG_FIRST]) || ((r == 2) && border_flags[FLAG_LAST]);
        cs = ((c == 0) && border_flags[FLAG_LEFT]) || ((c == 2) && border_flags[FLAG_RIGHT]);
        if (rs && cs) begin
          sel_rgb[r*3+c] = pix[PIX_CENTRE][23:0];
        end else if (rs) begin
          sel_rgb[r*3+c] = pix[3+c][23:0];
        end else if (cs) begin
          sel_rgb[r*3+c] = pix[r*3+1][23:0];
        end else begin
          sel_rgb[r*3+c] = pix[r*3+c][23:0];
        end
      end
    end
  end

  // upper row takes the trailing weight, lower row the leading weight
  assign wcol = {wx.trail, wx.middle, wx.lead};
  assign wrow = {wy.lead, wy.middle, wy.trail};

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      wx     <= axis_weights(frac_x);
      wy     <= axis_weights(frac_y);
      rgb1   <= sel_rgb;
      alpha1 <= pix[PIX_CENTRE][31:24];
    end
    if (adv.s2) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          w2[r*3+c] <= wgt2_t'(wrow[r]) * wgt2_t'(wcol[c]);
        end
      end
      rgb2   <= rgb1;
      alpha2 <= alpha1;
    end
  end

endmodule

// File: rtl/awpr_lane.sv
// One color channel lane: nine weight products (stage 3), three partial
// sums (stage 4), final add and truncation. Depends on awpr_pkg.
module awpr_lane (
  input  logic                                 clk,
  input  awpr_pkg::adv_t                       adv,
  input  awpr_pkg::wgt2_t [awpr_pkg::NPIX-1:0] w2,
  input  awpr_pkg::chan_t [awpr_pkg::NPIX-1:0] chan,
  output awpr_pkg::chan_t                      chan_out
);
  import awpr_pkg::*;

  prod_t [NPIX-1:0] prod;
  sum_t  [2:0]      part;
  sum_t             total;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      for (int k = 0; k < NPIX; k++) begin
        prod[k] <= prod_t'(w2[k]) * prod_t'(chan[k]);
      end
    end
    if (adv.s4) begin
      for (int g = 0; g < 3; g++) begin
        part[g] <= sum_t'(prod[g*3]) + sum_t'(prod[g*3+1]) + sum_t'(prod[g*3+2]);
      end
    end
  end

  // 2-D weights sum to one, so the result never exceeds 255
  assign total    = part[0] + part[1] + part[2];
  assign chan_out = total[SHIFT+7:SHIFT];

endmodule

// File: rtl/awpr_if_pack.sv
// (intentionally unused name avoided)

// File: rtl/area_weighted_pixel_resampler.sv
// Area weighted pixel resampler. Each input beat carries the fractional
// position of a sample point inside a source pixel plus that pixel's 3x3
// ARGB neighborhood; each output beat is one resampled ARGB pixel. A unit
// square centered on the point is overlapped with the nine pixels, giving
// per-axis weights in fixed point with FRAC_BITS fraction bits; red, green
// and blue are the truncated weighted sums, alpha is the center alpha.
// Border flags replace missing neighbors with the center row or column.
// Throughput is one beat per clock while the sink is ready. There are five
// register stages, the first written at the accepting edge. The pipeline
// is: input stage (border select, axis weights), 2-D weight multipliers,
// three channel lanes with nine products each, lane partial sums, and the
// merge/output register. Each stage holds its own valid bit, so an empty
// stage still takes a beat while the output register waits on a stalled
// sink.
// Depends on awpr_pkg, awpr_in_if, awpr_out_if, awpr_front, awpr_lane.
module area_weighted_pixel_resampler (
  input  logic    clk,
  input  logic    rst,
  awpr_in_if.sink   sample,
  awpr_out_if.source result
);
  import awpr_pkg::*;

  adv_t                     adv;
  logic [4:0]               vld;      // vld[0] = stage 1 ... vld[4] = output
  logic [NPIX-1:0][31:0]    pix;
  wgt2_t [NPIX-1:0]         w2;
  rgb_t  [NPIX-1:0]         rgb2;
  logic [7:0]               alpha2;
  logic [7:0]               alpha3;
  logic [7:0]               alpha4;
  chan_t [NCHAN-1:0]        lane_out;
  logic [7:0]               res_alpha;
  logic [7:0]               res_red;
  logic [7:0]               res_green;
  logic [7:0]               res_blue;

  // row-major, upper left first
  assign pix = {sample.pix_lower_right, sample.pix_lower_mid, sample.pix_lower_left,
                sample.pix_mid_right,   sample.pix_centre,    sample.pix_mid_left,
                sample.pix_upper_right, sample.pix_upper_mid, sample.pix_upper_left};

  // a stage advances when it is empty or the next one advances
  always_comb begin
    adv.s5 = !vld[4] || result.ready;
    adv.s4 = !vld[3] || adv.s5;
    adv.s3 = !vld[2] || adv.s4;
    adv.s2 = !vld[1] || adv.s3;
    adv.s1 = !vld[0] || adv.s2;
  end

  assign sample.ready = adv.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv.s1) vld[0] <= sample.valid;
      if (adv.s2) vld[1] <= vld[0];
      if (adv.s3) vld[2] <= vld[1];
      if (adv.s4) vld[3] <= vld[2];
      if (adv.s5) vld[4] <= vld[3];
    end
  end

  awpr_front u_front (
    .clk          (clk),
    .adv          (adv),
    .frac_x       (sample.frac_x),
    .frac_y       (sample.frac_y),
    .border_flags (sample.border_flags),
    .pix          (pix),
    .w2           (w2),
    .rgb2         (rgb2),
    .alpha2       (alpha2)
  );

  // lane 0 red, lane 1 green, lane 2 blue
  for (genvar ch = 0; ch < NCHAN; ch++) begin : g_lane
    chan_t [NPIX-1:0] chan;

    always_comb begin
      for (int k = 0; k < NPIX; k++) begin
        chan[k] = rgb2[k][23-8*ch -: 8];
      end
    end

    awpr_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .w2       (w2),
      .chan     (chan),
      .chan_out (lane_out[ch])
    );
  end

  // alpha rides alongside the lanes; merge into the output register
  always_ff @(posedge clk) begin
    if (adv.s3) alpha3 <= alpha2;
    if (adv.s4) alpha4 <= alpha3;
    if (adv.s5) begin
      res_alpha <= alpha4;
      res_red   <= lane_out[0];
      res_green <= lane_out[1];
      res_blue  <= lane_out[2];
    end
  end

  assign result.valid     = vld[4];
  assign result.out_alpha = res_alpha;
  assign result.out_red   = res_red;
  assign result.out_green = res_green;
  assign result.out_blue  = res_blue;

`ifndef SYNTHESIS
  logic [W2W+3:0] w2_total;

  always_comb begin
    w2_total = '0;
    for (int k = 0; k < NPIX; k++) begin
      w2_total = w2_total + (W2W+4)'(w2[k]);
    end
  end

  a_ready_when_room: assert property (@(posedge clk) disable iff (rst)
    (vld != 5'b11111) |-> sample.ready)
    else $error("input stalled with an empty pipeline stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> vld[0])
    else $error("accepted beat not captured in stage 1");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    !(result.valid && result.ready) |=> ($countones(vld) >= $past($countones(vld))))
    else $error("beat dropped inside the pipeline");

  a_weights_unit: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (w2_total == ((W2W+4)'(1) << SHIFT)))
    else $error("2-D weights do not sum to one");
`endif

endmodule

// File: bench/awpr_checker.sv
// Scoreboard for the area weighted pixel resampler: predicts each resampled
// ARGB pixel from the accepted sample beats and compares the result beats.
// Depends on awpr_pkg, awpr_in_if and awpr_out_if.
module awpr_checker (
  input  logic  clk,
  input  logic  rst,
  awpr_in_if    sample,
  awpr_out_if   result,
  output int    fail_count,
  output int    pending,
  output int    beats_in,
  output int    beats_out
);
  import awpr_pkg::*;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } argb_t;

  // per-axis overlap: lead = column-1 / lower row, trail = column+1 / upper row
  typedef struct packed {
    logic [63:0] lead;
    logic [63:0] mid;
    logic [63:0] trail;
  } span_t;

  argb_t expected_pixels[$];
  argb_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
    beats_in   = 0;
    beats_out  = 0;
  end

  function automatic span_t span_weights(input logic [7:0] f8);
    logic [63:0] one;
    logic [63:0] half;
    logic [63:0] f;
    span_t w;
    one  = 64'd1 << FRAC_BITS;
    half = one >> 1;
    if (FRAC_BITS >= 8) begin
      f = 64'(f8) << (FRAC_BITS >= 8 ? FRAC_BITS - 8 : 0);
    end else begin
      f = 64'(f8) >> (FRAC_BITS < 8 ? 8 - FRAC_BITS : 0);
    end
    w.lead  = (half > f) ? half - f : 64'd0;
    w.trail = (f > half) ? f - half : 64'd0;
    w.mid   = one - ((f > half) ? f - half : half - f);
    return w;
  endfunction

  // nb[0] is upper left, nb[8] lower right, row-major
  function automatic argb_t resample_pixel(input logic [7:0] fx, input logic [7:0] fy,
                                           input logic [3:0] flags,
                                           input logic [8:0][31:0] nb);
    span_t wx;
    span_t wy;
    logic [2:0][63:0] col_w;
    logic [2:0][63:0] row_w;
    int col_idx [0:2];
    int row_idx [0:2];
    logic [63:0] acc_r;
    logic [63:0] acc_g;
    logic [63:0] acc_b;
    logic [63:0] w;
    logic [31:0] p;
    argb_t res;
    wx = span_weights(fx);
    wy = span_weights(fy);
    col_w = {wx.trail, wx.mid, wx.lead};
    // upper row takes the after weight of fy, lower row the before weight
    row_w = {wy.lead, wy.mid, wy.trail};
    for (int k = 0; k < 3; k++) begin
      col_idx[k] = k;
      row_idx[k] = k;
    end
    if (flags[FLAG_LEFT])  col_idx[0] = 1;
    if (flags[FLAG_RIGHT]) col_idx[2] = 1;
    if (flags[FLAG_FIRST]) row_idx[0] = 1;
    if (flags[FLAG_LAST])  row_idx[2] = 1;
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p = nb[row_idx[r] * 3 + col_idx[c]];
        w = row_w[r] * col_w[c];
        acc_r += w * 64'(p[23:16]);
        acc_g += w * 64'(p[15:8]);
        acc_b += w * 64'(p[7:0]);
      end
    end
    res.alpha = nb[PIX_CENTRE][31:24];
    res.red   = 8'(acc_r >> SHIFT);
    res.green = 8'(acc_g >> SHIFT);
    res.blue  = 8'(acc_b >> SHIFT);
    return res;
  endfunction

  task automatic check_chan(input string name, input logic [7:0] exp_v,
                            input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (sample.valid && sample.ready) begin
        expected_pixels.push_back(resample_pixel(
          sample.frac_x, sample.frac_y, sample.border_flags,
          {sample.pix_lower_right, sample.pix_lower_mid, sample.pix_lower_left,
           sample.pix_mid_right, sample.pix_centre, sample.pix_mid_left,
           sample.pix_upper_right, sample.pix_upper_mid, sample.pix_upper_left}));
        beats_in++;
      end
      if (result.valid && result.ready) begin
        beats_out++;
        if (expected_pixels.size() == 0) begin
          $error("result beat with no pixel expected");
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_chan("out_alpha", want.alpha, result.out_alpha);
          check_chan("out_red",   want.red,   result.out_red);
          check_chan("out_green", want.green, result.out_green);
          check_chan("out_blue",  want.blue,  result.out_blue);
        end
      end
      pending = expected_pixels.size();
    end
  end

endmodule

// File: bench/testbench.sv
// Top of the resampler bench: clock, reset, sample stimulus, result-side
// back-pressure and the verdict. Depends on awpr_pkg, both channel
// interfaces, area_weighted_pixel_resampler and awpr_checker.
module testbench;
  import awpr_pkg::*;

  localparam int RANDOM_BEATS = 1530;
  localparam int QUIET_FROM   = 900;     // no idling on either side in here
  localparam int QUIET_TO     = 1200;
  localparam int STALL_AT     = 500;     // sample beats sent before the long hold-off
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;      // pipeline is five deep, leave margin
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int fail_count;
  int pending;
  int beats_in;
  int beats_out;
  int cycle_count = 0;
  int sent_count  = 0;
  bit quiet       = 1'b0;
  bit stall_done  = 1'b0;

  awpr_in_if  sample_ch ();
  awpr_out_if result_ch ();

  area_weighted_pixel_resampler uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  awpr_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .beats_in   (beats_in),
    .beats_out  (beats_out)
  );

  always #5 clk = ~clk;

  // Hard stop: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Fractions: lean on the corners of the weight math (0, 255, around half)
  // since that is where the before/after weights switch over.
  function automatic logic [7:0] rand_frac();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'(127 + $urandom_range(2));
      default: return 8'($urandom);
    endcase
  endfunction

  // Neighborhood with the odd saturated pixel mixed into random ones.
  function automatic logic [8:0][31:0] rand_block();
    logic [8:0][31:0] nb;
    for (int k = 0; k < 9; k++) begin
      case ($urandom_range(15))
        0:       nb[k] = '0;
        1:       nb[k] = '1;
        default: nb[k] = $urandom;
      endcase
    end
    return nb;
  endfunction

  // Half of the random beats get random border flags, any combination.
  function automatic logic [3:0] rand_flags();
    return $urandom_range(1) ? 4'($urandom) : 4'd0;
  endfunction

  // Drives one sample beat at the falling edge and holds it until taken.
  // Idle cycles before the beat drop valid; valid is written once per step.
  task automatic send_beat(input logic [7:0] fx, input logic [7:0] fy,
                           input logic [3:0] flags, input logic [8:0][31:0] nb);
    while (!quiet && $urandom_range(99) < 24) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.frac_x          <= fx;
    sample_ch.frac_y          <= fy;
    sample_ch.border_flags    <= flags;
    sample_ch.pix_upper_left  <= nb[0];
    sample_ch.pix_upper_mid   <= nb[1];
    sample_ch.pix_upper_right <= nb[2];
    sample_ch.pix_mid_left    <= nb[3];
    sample_ch.pix_centre      <= nb[4];
    sample_ch.pix_mid_right   <= nb[5];
    sample_ch.pix_lower_left  <= nb[6];
    sample_ch.pix_lower_mid   <= nb[7];
    sample_ch.pix_lower_right <= nb[8];
    sample_ch.valid           <= 1'b1;
    do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
    @(negedge clk);
    sent_count++;
  endtask

  // Result side: random ready, none in the quiet window, and one long
  // hold-off once enough beats went in, so the pipe backs up into the input.
  initial begin
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!stall_done && sent_count >= STALL_AT) begin
        stall_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end else begin
        result_ch.ready <= quiet || ($urandom_range(99) >= 24);
        @(negedge clk);
      end
    end
  end

  initial begin
    sample_ch.valid           = 1'b0;
    sample_ch.frac_x          = '0;
    sample_ch.frac_y          = '0;
    sample_ch.border_flags    = '0;
    sample_ch.pix_upper_left  = '0;
    sample_ch.pix_upper_mid   = '0;
    sample_ch.pix_upper_right = '0;
    sample_ch.pix_mid_left    = '0;
    sample_ch.pix_centre      = '0;
    sample_ch.pix_mid_right   = '0;
    sample_ch.pix_lower_left  = '0;
    sample_ch.pix_lower_mid   = '0;
    sample_ch.pix_lower_right = '0;

    // synchronous reset, released on a falling edge
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: black and white neighborhoods at the fraction extremes,
    // the exact-half point (outer weights zero), values either side of half.
    send_beat(8'd0,   8'd0,   4'd0, '0);
    send_beat(8'd255, 8'd255, 4'd0, '1);
    send_beat(8'd128, 8'd128, 4'd0, rand_block());
    send_beat(8'd127, 8'd129, 4'd0, rand_block());
    send_beat(8'd129, 8'd127, 4'd0, rand_block());

    // Every border flag pattern: single edges, both edges of an axis, corners.
    for (int f = 0; f < 16; f++) begin
      send_beat(rand_frac(), rand_frac(), 4'(f), rand_block());
    end

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      quiet = (n >= QUIET_FROM) && (n < QUIET_TO);
      send_beat(rand_frac(), rand_frac(), rand_flags(), rand_block());
    end
    quiet = 1'b0;
    sample_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    // catch any stray result beat the pipe may still emit
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run: %0d sample beats in, %0d result beats out.", beats_in, beats_out);
    $display("Covered all 16 border patterns, fractions 0/half/255 and a %0d-cycle output stall.",
             STALL_CYCLES);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
